// File: rtl/scan_result_dedupe_strongest_table_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the scan result table checker
// ----------------------------------------------------------------------------
`ifndef SCAN_RESULT_DEDUPE_STRONGEST_TABLE_MACROS_SVH
`define SCAN_RESULT_DEDUPE_STRONGEST_TABLE_MACROS_SVH

// same-cycle implication
`define SRDST_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SRDST_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/srdst_pkg.sv
// ----------------------------------------------------------------------------
// srdst_pkg
// Types and constants for the deduplicating scan result table.
// ----------------------------------------------------------------------------
package srdst_pkg;

    localparam int TABLE_DEPTH = 24;
    localparam int NAME_BYTES  = 32;

    localparam int NAME_WORDS  = 4;
    localparam int WORD_W      = 64;
    localparam int LEN_IN_W    = 8;
    localparam int LEN_W       = 6;
    localparam int LEVEL_W     = 16;
    localparam int CHAN_W      = 16;
    localparam int SEC_W       = 8;
    localparam int CMD_W       = 2;

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    localparam int IN_DATA_W  = 304;
    localparam int OUT_DATA_W = 304;

    typedef logic [NAME_WORDS-1:0][WORD_W-1:0] name_t;

    // request payload as it sits on the input tdata, name in the low bits
    typedef struct packed {
        logic [SEC_W-1:0]          sec;
        logic [CHAN_W-1:0]         chan;
        logic signed [LEVEL_W-1:0] level;
        logic [LEN_IN_W-1:0]       len;
        name_t                     name;
    } sighting_t;

    // one table entry, also the low bits of the output tdata
    typedef struct packed {
        logic [SEC_W-1:0]          sec;
        logic [CHAN_W-1:0]         chan;
        logic signed [LEVEL_W-1:0] level;
        logic [LEN_W-1:0]          len;
        name_t                     name;
    } entry_t;

    localparam int PAD_W = OUT_DATA_W - $bits(entry_t);

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_RECORD = 2'd1,
        CMD_READ   = 2'd2
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXTRACT,
        ST_SEARCH_RD,
        ST_SEARCH_CMP,
        ST_SORT_KEY_RD,
        ST_SORT_KEY_LD,
        ST_SORT_RD,
        ST_SORT_CMP,
        ST_OUT_RD,
        ST_OUT_LD
    } state_t;

endpackage

// File: rtl/scan_result_dedupe_strongest_table.sv
// ----------------------------------------------------------------------------
// scan_result_dedupe_strongest_table
// Table of radio sightings kept unique by name, holding the strongest level
// per name; sorts itself strongest first and streams out on a read request.
// ----------------------------------------------------------------------------
// Channel   Dir  Signals                       Contents
// s_axis    in   tvalid tready tdata tuser     one command request
// m_axis    out  tvalid tready tdata tuser     one table entry per transfer
//                tlast                         (last of a readout)
//
// Sequence: a clear is handled in the idle state. A record request runs name
// extraction (one 64-bit word a cycle), then a search of the stored entries
// by the single name comparator, then the write of a new or stronger entry.
// A read request runs an in-place insertion sort through the one-read,
// one-write table memory (a read state and a compare/move state per step),
// then an output-read and an output-load state per entry out. Reset clears
// the entry count and control state only; the table memory needs no clearing
// pass. A stalled output holds the sequencer in the output-load state;
// s_axis_tready is high only while the sequencer is idle.
// ----------------------------------------------------------------------------
module scan_result_dedupe_strongest_table
(
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // name_word0, name_word1, name_word2, name_word3, name_length,
    // signal_level, radio_channel, security_bits
    input  logic [srdst_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // command
    input  logic [srdst_pkg::CMD_W-1:0]      s_axis_tuser,

    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // out_word0, out_word1, out_word2, out_word3, out_length, out_level,
    // out_channel, out_security, two zero pad bits
    output logic [srdst_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // entry_valid
    output logic                             m_axis_tuser,
    output logic                             m_axis_tlast
);

    srdst_pkg::state_t state_reg, state_next;

    logic [srdst_pkg::CNT_W-1:0] count_reg, count_next;
    logic [srdst_pkg::CNT_W-1:0] idx_reg,   idx_next;
    logic [srdst_pkg::CNT_W-1:0] j_reg,     j_next;

    // record path
    srdst_pkg::sighting_t        in_reg,      in_next;
    logic [srdst_pkg::LEN_W-1:0] len_cap_reg, len_cap_next;
    logic [1:0]                  word_idx_reg, word_idx_next;
    logic                        alive_reg,   alive_next;
    logic [srdst_pkg::LEN_W-1:0] eff_reg,     eff_next;
    srdst_pkg::name_t            name_reg,    name_next;

    // sort key
    srdst_pkg::entry_t key_reg, key_next;

    // output register
    logic              m_valid_reg, m_valid_next;
    srdst_pkg::entry_t out_entry_reg, out_entry_next;
    logic              out_flag_reg, out_flag_next;
    logic              out_last_reg, out_last_next;

    // table memory
    srdst_pkg::entry_t table_mem [srdst_pkg::TABLE_DEPTH];
    srdst_pkg::entry_t rd_data_reg;
    logic                        rd_en;
    logic [srdst_pkg::IDX_W-1:0] rd_addr;
    logic                        wr_en;
    logic [srdst_pkg::IDX_W-1:0] wr_addr;
    srdst_pkg::entry_t           wr_data;

    // extraction of one name word
    logic [srdst_pkg::WORD_W-1:0] ext_word;
    logic [srdst_pkg::WORD_W-1:0] ext_built;
    logic                         ext_alive;
    logic [srdst_pkg::LEN_W-1:0]  ext_eff;

    srdst_pkg::sighting_t in_req;
    logic                 out_free;

    assign in_req        = srdst_pkg::sighting_t'(s_axis_tdata);
    assign s_axis_tready = (state_reg == srdst_pkg::ST_IDLE);
    assign out_free      = !m_valid_reg || m_axis_tready;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{srdst_pkg::PAD_W{1'b0}}, out_entry_reg};
    assign m_axis_tuser  = out_flag_reg;
    assign m_axis_tlast  = out_last_reg;

    // Byte scan of one word: a byte is kept while it lies below the capped
    // length and no zero byte has been seen yet.
    always_comb
    begin
        logic [7:0] byte_val;
        logic [5:0] pos;
        ext_word  = in_reg.name[word_idx_reg];
        ext_built = '0;
        ext_alive = alive_reg;
        ext_eff   = eff_reg;
        for (int k = 0; k < 8; k++)
        begin
            byte_val = ext_word[k*8 +: 8];
            pos      = {1'b0, word_idx_reg, 3'(k)};
            if (ext_alive && (pos < len_cap_reg) && (byte_val != 8'd0))
            begin
                ext_built[k*8 +: 8] = byte_val;
                ext_eff             = ext_eff + srdst_pkg::LEN_W'(1);
            end
            else
            begin
                ext_alive = 1'b0;
            end
        end
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        j_next         = j_reg;
        in_next        = in_reg;
        len_cap_next   = len_cap_reg;
        word_idx_next  = word_idx_reg;
        alive_next     = alive_reg;
        eff_next       = eff_reg;
        name_next      = name_reg;
        key_next       = key_reg;
        m_valid_next   = m_valid_reg && !m_axis_tready;
        out_entry_next = out_entry_reg;
        out_flag_next  = out_flag_reg;
        out_last_next  = out_last_reg;
        rd_en          = 1'b0;
        rd_addr        = idx_reg[srdst_pkg::IDX_W-1:0];
        wr_en          = 1'b0;
        wr_addr        = idx_reg[srdst_pkg::IDX_W-1:0];
        wr_data        = key_reg;

        case (state_reg)
            srdst_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    case (srdst_pkg::cmd_t'(s_axis_tuser))
                        srdst_pkg::CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        srdst_pkg::CMD_RECORD:
                        begin
                            // hidden names are ignored
                            if (in_req.len != '0)
                            begin
                                in_next = in_req;
                                if (in_req.len > srdst_pkg::LEN_IN_W'(srdst_pkg::NAME_BYTES))
                                    len_cap_next = srdst_pkg::LEN_W'(srdst_pkg::NAME_BYTES);
                                else
                                    len_cap_next = in_req.len[srdst_pkg::LEN_W-1:0];
                                word_idx_next = '0;
                                alive_next    = 1'b1;
                                eff_next      = '0;
                                name_next     = '0;
                                state_next    = srdst_pkg::ST_EXTRACT;
                            end
                        end
                        srdst_pkg::CMD_READ:
                        begin
                            idx_next   = srdst_pkg::CNT_W'(1);
                            state_next = srdst_pkg::ST_SORT_KEY_RD;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            srdst_pkg::ST_EXTRACT:
            begin
                name_next[word_idx_reg] = ext_built;
                alive_next              = ext_alive;
                eff_next                = ext_eff;
                word_idx_next           = word_idx_reg + 2'd1;
                if (word_idx_reg == 2'(srdst_pkg::NAME_WORDS - 1))
                begin
                    idx_next   = '0;
                    state_next = srdst_pkg::ST_SEARCH_RD;
                end
            end

            srdst_pkg::ST_SEARCH_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    // no match: append if there is room, else drop
                    if (count_reg < srdst_pkg::CNT_W'(srdst_pkg::TABLE_DEPTH))
                    begin
                        wr_en         = 1'b1;
                        wr_addr       = count_reg[srdst_pkg::IDX_W-1:0];
                        wr_data.name  = name_reg;
                        wr_data.len   = eff_reg;
                        wr_data.level = in_reg.level;
                        wr_data.chan  = in_reg.chan;
                        wr_data.sec   = in_reg.sec;
                        count_next    = count_reg + srdst_pkg::CNT_W'(1);
                    end
                    state_next = srdst_pkg::ST_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = srdst_pkg::ST_SEARCH_CMP;
                end
            end

            srdst_pkg::ST_SEARCH_CMP:
            begin
                if (rd_data_reg.name == name_reg)
                begin
                    // strictly stronger replaces level, channel and security
                    if ($signed(in_reg.level) > $signed(rd_data_reg.level))
                    begin
                        wr_en         = 1'b1;
                        wr_data       = rd_data_reg;
                        wr_data.level = in_reg.level;
                        wr_data.chan  = in_reg.chan;
                        wr_data.sec   = in_reg.sec;
                    end
                    state_next = srdst_pkg::ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + srdst_pkg::CNT_W'(1);
                    state_next = srdst_pkg::ST_SEARCH_RD;
                end
            end

            srdst_pkg::ST_SORT_KEY_RD:
            begin
                if (idx_reg >= count_reg)
                begin
                    idx_next   = '0;
                    state_next = srdst_pkg::ST_OUT_RD;
                end
                else
                begin
                    rd_en      = 1'b1;
                    j_next     = idx_reg;
                    state_next = srdst_pkg::ST_SORT_KEY_LD;
                end
            end

            srdst_pkg::ST_SORT_KEY_LD:
            begin
                key_next   = rd_data_reg;
                state_next = srdst_pkg::ST_SORT_RD;
            end

            srdst_pkg::ST_SORT_RD:
            begin
                if (j_reg == '0)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = '0;
                    idx_next   = idx_reg + srdst_pkg::CNT_W'(1);
                    state_next = srdst_pkg::ST_SORT_KEY_RD;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = j_reg[srdst_pkg::IDX_W-1:0] - srdst_pkg::IDX_W'(1);
                    state_next = srdst_pkg::ST_SORT_CMP;
                end
            end

            srdst_pkg::ST_SORT_CMP:
            begin
                wr_en   = 1'b1;
                wr_addr = j_reg[srdst_pkg::IDX_W-1:0];
                // strictly weaker neighbor moves up; ties keep their order
                if ($signed(rd_data_reg.level) < $signed(key_reg.level))
                begin
                    wr_data    = rd_data_reg;
                    j_next     = j_reg - srdst_pkg::CNT_W'(1);
                    state_next = srdst_pkg::ST_SORT_RD;
                end
                else
                begin
                    idx_next   = idx_reg + srdst_pkg::CNT_W'(1);
                    state_next = srdst_pkg::ST_SORT_KEY_RD;
                end
            end

            srdst_pkg::ST_OUT_RD:
            begin
                rd_en      = (count_reg != '0);
                state_next = srdst_pkg::ST_OUT_LD;
            end

            srdst_pkg::ST_OUT_LD:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    if (count_reg == '0)
                    begin
                        out_entry_next = '0;
                        out_flag_next  = 1'b0;
                        out_last_next  = 1'b1;
                        state_next     = srdst_pkg::ST_IDLE;
                    end
                    else
                    begin
                        out_entry_next = rd_data_reg;
                        out_flag_next  = 1'b1;
                        out_last_next  = 1'b0;
                        idx_next       = idx_reg + srdst_pkg::CNT_W'(1);
                        state_next     = srdst_pkg::ST_OUT_RD;
                        if (idx_reg + srdst_pkg::CNT_W'(1) == count_reg)
                        begin
                            out_last_next = 1'b1;
                            state_next    = srdst_pkg::ST_IDLE;
                        end
                    end
                end
            end

            default:
            begin
                state_next = srdst_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= srdst_pkg::ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload and working registers
    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        j_reg         <= j_next;
        in_reg        <= in_next;
        len_cap_reg   <= len_cap_next;
        word_idx_reg  <= word_idx_next;
        alive_reg     <= alive_next;
        eff_reg       <= eff_next;
        name_reg      <= name_next;
        key_reg       <= key_next;
        out_entry_reg <= out_entry_next;
        out_flag_reg  <= out_flag_next;
        out_last_reg  <= out_last_next;
    end

    // Table memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            table_mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= table_mem[rd_addr];
    end

endmodule

// File: rtl/srdst_checker.sv
// ----------------------------------------------------------------------------
// srdst_checker
// Port-level checks for the scan result table, bound to the top level.
// ----------------------------------------------------------------------------
`include "scan_result_dedupe_strongest_table_macros.svh"

module srdst_checker
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic [srdst_pkg::CMD_W-1:0]      s_axis_tuser,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [srdst_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                             m_axis_tuser,
    input  logic                             m_axis_tlast
);

    logic                               s_fire;
    logic                               read_fire;
    logic                               clear_fire;
    logic                               out_stall;
    logic                               empty_out;
    logic [srdst_pkg::OUT_DATA_W+1:0]   out_bus;

    assign s_fire     = s_axis_tvalid && s_axis_tready;
    assign read_fire  = s_fire && (s_axis_tuser == srdst_pkg::CMD_READ);
    assign clear_fire = s_fire && (s_axis_tuser == srdst_pkg::CMD_CLEAR);
    assign out_stall  = m_axis_tvalid && !m_axis_tready;
    assign empty_out  = m_axis_tvalid && !m_axis_tuser;
    assign out_bus    = {m_axis_tuser, m_axis_tlast, m_axis_tdata};

    // stalled result stays valid and unchanged
    `SRDST_ASSERT_NXT(a_out_valid, clk, rst_n, out_stall, m_axis_tvalid, "stalled result dropped")
    `SRDST_ASSERT_NXT(a_out_hold, clk, rst_n, out_stall, $stable(out_bus), "result changed")

    // empty-table result is always the end of its readout
    `SRDST_ASSERT_IMP(a_empty_last, clk, rst_n, empty_out, m_axis_tlast, "empty without last")

    // a read request keeps the block busy
    `SRDST_ASSERT_NXT(a_read_busy, clk, rst_n, read_fire, !s_axis_tready, "ready after read")

    // clear returns the block to ready in the next cycle
    `SRDST_ASSERT_NXT(a_clear_ready, clk, rst_n, clear_fire, s_axis_tready, "busy after clear")

endmodule

bind scan_result_dedupe_strongest_table srdst_checker u_srdst_checker (.*);
